@@ hdl/dsd_pkg.sv @@
// shared types, constants and helper functions for the sample deframer
package dsd_pkg;

  localparam int CHANNELS      = 8;
  localparam int SAMPLE_BITS   = 12;
  localparam int HEADER_WORDS  = 6;
  localparam int STREAM_BITS   = 32;
  localparam int POS_BITS      = 30;
  localparam int CHAN_BITS     = 3;
  localparam int NCHAN_BITS    = 4;
  localparam int HI_SHIFT      = 16;
  localparam int DIV_STEPS     = POS_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);

  localparam logic [POS_BITS-1:0] MASK_WORD  = POS_BITS'(3);
  localparam logic [POS_BITS-1:0] HDR_WORDS  = POS_BITS'(HEADER_WORDS);
  localparam logic [POS_BITS-1:0] HDR_LAST   = POS_BITS'(HEADER_WORDS - 1);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LO,
    ST_HI
  } dsd_state_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dsd_div_stat_t;

  // number of enabled channels
  function automatic logic [NCHAN_BITS-1:0] count_bits(input logic [CHANNELS-1:0] m);
    logic [NCHAN_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      n = n + NCHAN_BITS'(m[i]);
    end
    return n;
  endfunction

  // lowest enabled channel at or above from
  function automatic logic [CHAN_BITS-1:0] next_chan(input logic [CHANNELS-1:0] m,
                                                     input logic [NCHAN_BITS-1:0] from);
    logic [CHAN_BITS-1:0] c;
    c = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (m[i] && (NCHAN_BITS'(i) >= from)) begin
        c = CHAN_BITS'(i);
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/dsd_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module dsd_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [dsd_pkg::POS_BITS-1:0]     dividend,
  input  logic [dsd_pkg::NCHAN_BITS-1:0]   divisor,
  output dsd_pkg::dsd_div_stat_t           stat,
  output logic [dsd_pkg::POS_BITS-1:0]     quotient
);

  logic [dsd_pkg::POS_BITS-1:0]     quo_r;
  logic [dsd_pkg::NCHAN_BITS-1:0]   rem_r;
  logic [dsd_pkg::NCHAN_BITS-1:0]   div_r;
  logic [dsd_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic [dsd_pkg::NCHAN_BITS:0]     trial;
  logic [dsd_pkg::NCHAN_BITS:0]     rem_step;
  logic                             ge;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem_r, quo_r[dsd_pkg::POS_BITS-1]};
    ge       = (trial >= {1'b0, div_r});
    rem_step = ge ? (trial - {1'b0, div_r}) : trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= dsd_pkg::DIV_CNT_BITS'(dsd_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == dsd_pkg::DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[dsd_pkg::POS_BITS-2:0], ge};
      rem_r <= rem_step[dsd_pkg::NCHAN_BITS-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ hdl/digitizer_event_sample_deframer.sv @@
// top level: event word sequencer, channel planning and sample output register
//
//  channel | ports                                        | direction
//  in      | in_valid, in_ready, in_stream_word           | stream words in
//  out     | out_valid, out_ready, out_channel,           | samples out
//          | out_sample_value, out_last_in_channel,       |
//          | out_last_in_event                            |
//
// a header or skipped word needs only its accept; a data word is accepted, then its
// low and high samples are loaded into the output register in turn.
// the last header word, when the mask is non-zero, also waits for the serial
// divider, which yields one quotient bit per cycle for the 30-bit words-per-channel.
// synchronous active-low reset returns to the start of an event.
// a stalled output holds the sequencer in a sample state; in_ready stays low.
module digitizer_event_sample_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dsd_pkg::STREAM_BITS-1:0]     in_stream_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dsd_pkg::CHAN_BITS-1:0]       out_channel,
  output logic [dsd_pkg::SAMPLE_BITS-1:0]     out_sample_value,
  output logic                                out_last_in_channel,
  output logic                                out_last_in_event
);

  dsd_pkg::dsd_state_t              state_r, state_nxt;
  logic [dsd_pkg::POS_BITS-1:0]     pos_r, pos_nxt;
  logic [dsd_pkg::POS_BITS-1:0]     ev_words_r, ev_words_nxt;
  logic [dsd_pkg::CHANNELS-1:0]     mask_r, mask_nxt;
  logic [dsd_pkg::POS_BITS-1:0]     wpc_r, wpc_nxt;
  logic [dsd_pkg::CHAN_BITS-1:0]    cur_ch_r, cur_ch_nxt;
  logic [dsd_pkg::POS_BITS-1:0]     wleft_r, wleft_nxt;
  logic [dsd_pkg::NCHAN_BITS-1:0]   chleft_r, chleft_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // held beat for the two sample emissions
  logic [dsd_pkg::SAMPLE_BITS-1:0]  lo_r, hi_r;
  logic [dsd_pkg::CHAN_BITS-1:0]    emit_ch_r;
  logic                             last_ch_r, last_ev_r;
  logic                             hold_load;

  // output register payload
  logic [dsd_pkg::CHAN_BITS-1:0]    o_ch_r;
  logic [dsd_pkg::SAMPLE_BITS-1:0]  o_smp_r;
  logic                             o_lch_r, o_lev_r;
  logic                             out_load, out_hi;

  logic                             accept;
  logic                             out_free;
  logic [dsd_pkg::NCHAN_BITS-1:0]   n_en;
  logic [dsd_pkg::POS_BITS-1:0]     pos_inc;
  logic [dsd_pkg::POS_BITS-1:0]     words_raw;
  logic                             div_start;
  dsd_pkg::dsd_div_stat_t           div_stat;
  logic [dsd_pkg::POS_BITS-1:0]     div_q;
  logic [dsd_pkg::POS_BITS-1:0]     div_dividend;

  assign in_ready  = (state_r == dsd_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign n_en      = dsd_pkg::count_bits(mask_r);
  assign words_raw = in_stream_word[dsd_pkg::STREAM_BITS-1:2];
  assign div_dividend = ev_words_r - dsd_pkg::HDR_WORDS;

  // words per channel = (event words - header) / enabled channels
  dsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_en),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    ev_words_nxt  = ev_words_r;
    mask_nxt      = mask_r;
    wpc_nxt       = wpc_r;
    cur_ch_nxt    = cur_ch_r;
    wleft_nxt     = wleft_r;
    chleft_nxt    = chleft_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    hold_load     = 1'b0;
    out_load      = 1'b0;
    out_hi        = 1'b0;
    pos_inc       = pos_r + 1'b1;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dsd_pkg::ST_IDLE: begin
        if (accept) begin
          if (pos_r == '0) begin
            // size word opens the event
            ev_words_nxt = (words_raw < dsd_pkg::HDR_WORDS) ? dsd_pkg::HDR_WORDS : words_raw;
            mask_nxt     = '0;
            chleft_nxt   = '0;
            wleft_nxt    = '0;
          end else if (pos_r < dsd_pkg::HDR_WORDS) begin
            if (pos_r == dsd_pkg::MASK_WORD) begin
              mask_nxt = in_stream_word[dsd_pkg::CHANNELS-1:0];
            end
            if (pos_r == dsd_pkg::HDR_LAST) begin
              chleft_nxt = '0;
              wleft_nxt  = '0;
              cur_ch_nxt = '0;
              wpc_nxt    = '0;
              if (n_en != '0) begin
                div_start = 1'b1;
                state_nxt = dsd_pkg::ST_DIV;
              end
            end
          end else if (chleft_r != '0 && wleft_r != '0) begin
            // data word: two samples follow
            hold_load = 1'b1;
            state_nxt = dsd_pkg::ST_LO;
            wleft_nxt = wleft_r - 1'b1;
            if (wleft_r == dsd_pkg::POS_BITS'(1)) begin
              chleft_nxt = chleft_r - 1'b1;
              if (chleft_r != dsd_pkg::NCHAN_BITS'(1)) begin
                cur_ch_nxt = dsd_pkg::next_chan(mask_r,
                                                {1'b0, cur_ch_r} + dsd_pkg::NCHAN_BITS'(1));
                wleft_nxt  = wpc_r;
              end
            end
          end
          pos_nxt = (pos_inc >= ev_words_nxt) ? '0 : pos_inc;
        end
      end
      dsd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          wpc_nxt   = div_q;
          state_nxt = dsd_pkg::ST_IDLE;
          if (div_q != '0) begin
            chleft_nxt = n_en;
            cur_ch_nxt = dsd_pkg::next_chan(mask_r, '0);
            wleft_nxt  = div_q;
          end
        end
      end
      dsd_pkg::ST_LO: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dsd_pkg::ST_HI;
        end
      end
      dsd_pkg::ST_HI: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_hi        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dsd_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsd_pkg::ST_IDLE;
      pos_r       <= '0;
      ev_words_r  <= '0;
      mask_r      <= '0;
      wpc_r       <= '0;
      cur_ch_r    <= '0;
      wleft_r     <= '0;
      chleft_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      ev_words_r  <= ev_words_nxt;
      mask_r      <= mask_nxt;
      wpc_r       <= wpc_nxt;
      cur_ch_r    <= cur_ch_nxt;
      wleft_r     <= wleft_nxt;
      chleft_r    <= chleft_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // held data beat
  always_ff @(posedge clk) begin
    if (hold_load) begin
      lo_r      <= in_stream_word[dsd_pkg::SAMPLE_BITS-1:0];
      hi_r      <= in_stream_word[dsd_pkg::HI_SHIFT +: dsd_pkg::SAMPLE_BITS];
      emit_ch_r <= cur_ch_r;
      last_ch_r <= (wleft_r == dsd_pkg::POS_BITS'(1));
      last_ev_r <= (wleft_r == dsd_pkg::POS_BITS'(1)) &&
                   (chleft_r == dsd_pkg::NCHAN_BITS'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ch_r  <= emit_ch_r;
      o_smp_r <= out_hi ? hi_r : lo_r;
      o_lch_r <= out_hi && last_ch_r;
      o_lev_r <= out_hi && last_ev_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_channel         = o_ch_r;
  assign out_sample_value    = o_smp_r;
  assign out_last_in_channel = o_lch_r;
  assign out_last_in_event   = o_lev_r;

endmodule

@@ tb/sv/dsd_sample_checker.sv @@
// sample checker for the deframer: predicts samples from stream beats and compares
`timescale 1ns / 1ps

module dsd_sample_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [dsd_pkg::STREAM_BITS-1:0]   in_stream_word,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [dsd_pkg::CHAN_BITS-1:0]     out_channel,
  input  logic [dsd_pkg::SAMPLE_BITS-1:0]   out_sample_value,
  input  logic                              out_last_in_channel,
  input  logic                              out_last_in_event,
  output int                                n_errors,
  output int                                n_pending,
  output int                                n_samples,
  output int                                n_events
);

  typedef struct packed {
    logic [dsd_pkg::CHAN_BITS-1:0]   channel;
    logic [dsd_pkg::SAMPLE_BITS-1:0] value;
    logic                            last_chan;
    logic                            last_event;
  } sample_t;

  // samples still owed by the block, oldest first
  sample_t expected_samples[$];
  sample_t want;

  // own copy of the deframing state
  logic [dsd_pkg::POS_BITS-1:0]   word_pos;
  logic [dsd_pkg::POS_BITS-1:0]   event_len;
  logic [dsd_pkg::POS_BITS-1:0]   words_per_chan;
  logic [dsd_pkg::POS_BITS-1:0]   chan_words_left;
  logic [dsd_pkg::CHANNELS-1:0]   chan_mask;
  logic [dsd_pkg::CHAN_BITS-1:0]  active_chan;
  logic [dsd_pkg::NCHAN_BITS-1:0] chans_left;

  int errors = 0;
  int samples = 0;
  int events = 0;

  // lowest enabled channel at or above a start point
  function automatic logic [dsd_pkg::CHAN_BITS-1:0] lowest_enabled(input int from);
    logic [dsd_pkg::CHAN_BITS-1:0] c;
    c = '0;
    for (int i = dsd_pkg::CHANNELS - 1; i >= from; i--) begin
      if (chan_mask[i]) c = dsd_pkg::CHAN_BITS'(i);
    end
    return c;
  endfunction

  // split the data words of the event between the enabled channels
  task automatic plan_channels();
    int n;
    n = 0;
    for (int i = 0; i < dsd_pkg::CHANNELS; i++) n += int'(chan_mask[i]);
    chans_left      = '0;
    chan_words_left = '0;
    active_chan     = '0;
    words_per_chan  = '0;
    if (n != 0) begin
      words_per_chan = dsd_pkg::POS_BITS'((event_len - dsd_pkg::HDR_WORDS) /
                                          dsd_pkg::POS_BITS'(n));
      if (words_per_chan != '0) begin
        chans_left      = dsd_pkg::NCHAN_BITS'(n);
        active_chan     = lowest_enabled(0);
        chan_words_left = words_per_chan;
      end
    end
  endtask

  // advance by one stream word and queue the samples it yields
  task automatic deframe_word(input logic [dsd_pkg::STREAM_BITS-1:0] w);
    logic [dsd_pkg::POS_BITS-1:0] len;
    sample_t s;
    if (word_pos == '0) begin
      len = w[dsd_pkg::STREAM_BITS-1:2];
      if (len < dsd_pkg::HDR_WORDS) len = dsd_pkg::HDR_WORDS;
      event_len       = len;
      chan_mask       = '0;
      chans_left      = '0;
      chan_words_left = '0;
      events++;
    end else if (word_pos < dsd_pkg::HDR_WORDS) begin
      if (word_pos == dsd_pkg::MASK_WORD) chan_mask = w[dsd_pkg::CHANNELS-1:0];
      if (word_pos == dsd_pkg::HDR_LAST) plan_channels();
    end else if (chans_left != '0 && chan_words_left != '0) begin
      // low sample never closes anything
      s.channel    = active_chan;
      s.value      = w[dsd_pkg::SAMPLE_BITS-1:0];
      s.last_chan  = 1'b0;
      s.last_event = 1'b0;
      expected_samples.insert(expected_samples.size(), s);
      s.value      = w[dsd_pkg::HI_SHIFT +: dsd_pkg::SAMPLE_BITS];
      s.last_chan  = (chan_words_left == dsd_pkg::POS_BITS'(1));
      s.last_event = s.last_chan && (chans_left == dsd_pkg::NCHAN_BITS'(1));
      expected_samples.insert(expected_samples.size(), s);
      chan_words_left = chan_words_left - 1'b1;
      if (chan_words_left == '0) begin
        chans_left = chans_left - 1'b1;
        if (chans_left != '0) begin
          active_chan     = lowest_enabled(int'(active_chan) + 1);
          chan_words_left = words_per_chan;
        end
      end
    end
    word_pos = word_pos + 1'b1;
    if (word_pos >= event_len) word_pos = '0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("checker: sample %0d %s: got %0d, expected %0d", samples, what, got, exp_val);
    errors++;
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      word_pos        = '0;
      event_len       = '0;
      words_per_chan  = '0;
      chan_words_left = '0;
      chan_mask       = '0;
      active_chan     = '0;
      chans_left      = '0;
      expected_samples.delete();
    end else begin
      if (in_valid && in_ready) deframe_word(in_stream_word);
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("arrived with none expected, channel", int'(out_channel), -1);
        end else begin
          want = expected_samples.pop_front();
          if (out_channel !== want.channel)
            report_mismatch("channel", int'(out_channel), int'(want.channel));
          if (out_sample_value !== want.value)
            report_mismatch("value", int'(out_sample_value), int'(want.value));
          if (out_last_in_channel !== want.last_chan)
            report_mismatch("last in channel", int'(out_last_in_channel), int'(want.last_chan));
          if (out_last_in_event !== want.last_event)
            report_mismatch("last in event", int'(out_last_in_event), int'(want.last_event));
        end
        samples++;
      end
    end
    n_errors  <= errors;
    n_pending <= expected_samples.size();
    n_samples <= samples;
    n_events  <= events;
  end

endmodule

@@ tb/sv/tb_digitizer_event_sample_deframer.sv @@
// testbench top for the sample deframer: stream stimulus, output back-pressure and verdict
`timescale 1ns / 1ps

module tb_digitizer_event_sample_deframer;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int WORD_TARGET  = 1300;
  localparam int CALM_AFTER   = 1100;
  localparam int TAIL_WORDS   = 22;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 250;
  localparam int MODE_PERIOD  = 96;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [dsd_pkg::STREAM_BITS-1:0] in_stream_word = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [dsd_pkg::CHAN_BITS-1:0]   out_channel;
  logic [dsd_pkg::SAMPLE_BITS-1:0] out_sample_value;
  logic                            out_last_in_channel;
  logic                            out_last_in_event;

  int n_errors;
  int n_pending;
  int n_samples;
  int n_events;

  logic calm = 1'b0;
  logic tx_noisy = 1'b0;
  int   words_sent = 0;
  int   idle_cycles = 0;

  // receiver side state
  int   rx_beats = 0;
  int   rx_cycle = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  logic hold_done = 1'b0;
  logic rx_noisy = 1'b1;

  logic [dsd_pkg::STREAM_BITS-1:0] directed_words[$];

  always #HALF_PERIOD clk = ~clk;

  digitizer_event_sample_deframer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_stream_word      (in_stream_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_channel         (out_channel),
    .out_sample_value    (out_sample_value),
    .out_last_in_channel (out_last_in_channel),
    .out_last_in_event   (out_last_in_event)
  );

  dsd_sample_checker sample_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_stream_word      (in_stream_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_channel         (out_channel),
    .out_sample_value    (out_sample_value),
    .out_last_in_channel (out_last_in_channel),
    .out_last_in_event   (out_last_in_event),
    .n_errors            (n_errors),
    .n_pending           (n_pending),
    .n_samples           (n_samples),
    .n_events            (n_events)
  );

  // sample receiver: short random stalls, one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (out_valid && out_ready) rx_beats++;
    rx_cycle++;
    if (rx_cycle % MODE_PERIOD == 0) rx_noisy = ($urandom_range(0, 2) != 0);
    if (!hold_done && rx_beats >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && rx_noisy && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // mostly random data, now and then all zeros or all ones
  function automatic logic [dsd_pkg::STREAM_BITS-1:0] data_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // offer one stream beat and hold it until taken, then maybe leave a gap
  task automatic send_word(input logic [dsd_pkg::STREAM_BITS-1:0] w);
    in_valid       <= 1'b1;
    in_stream_word <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (!calm && tx_noisy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // one whole event: size word, header with the mask word, then data
  task automatic send_event(input logic [dsd_pkg::STREAM_BITS-1:0] size_word,
                            input logic [dsd_pkg::STREAM_BITS-1:0] mask_word);
    int len;
    len = int'(size_word[dsd_pkg::STREAM_BITS-1:2]);
    if (len < dsd_pkg::HEADER_WORDS) len = dsd_pkg::HEADER_WORDS;
    tx_noisy = ($urandom_range(0, 3) != 0);
    send_word(size_word);
    for (int i = 1; i < len; i++) begin
      send_word((i == int'(dsd_pkg::MASK_WORD)) ? mask_word : data_word());
    end
  endtask

  initial begin
    int pick;
    int len;
    logic [dsd_pkg::STREAM_BITS-1:0] mask;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed events
    directed_words = '{
      // size below the header length, all mask bits set: header only
      32'h0000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      // byte count not a word multiple, channel 7 only with high mask bits set
      32'd39, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF80, 32'h0000_0000, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h0000_0000, 32'h0FFF_0FFF,
      // zero mask with leftover words
      32'd32, 32'h1111_1111, 32'h2222_2222, 32'hFFFF_FF00, 32'h3333_3333, 32'h4444_4444,
      32'h1234_5678, 32'h8765_4321
    };
    tx_noisy = 1'b1;
    foreach (directed_words[i]) send_word(directed_words[i]);

    // random events, mostly well-formed with a spread of masks and sizes
    while (words_sent < WORD_TARGET - TAIL_WORDS) begin
      if (words_sent >= CALM_AFTER) calm <= 1'b1;
      pick = $urandom_range(0, 19);
      mask = $urandom;
      len  = $urandom_range(dsd_pkg::HEADER_WORDS, 32);
      if (pick <= 1) begin
        // short event: size below the header length
        send_event(dsd_pkg::STREAM_BITS'($urandom_range(0, 4 * dsd_pkg::HEADER_WORDS - 1)),
                   mask);
      end else begin
        if (pick == 2) begin
          mask[dsd_pkg::CHANNELS-1:0] = '0;
        end else if (pick == 3) begin
          mask[dsd_pkg::CHANNELS-1:0] = '1;
          len = $urandom_range(dsd_pkg::HEADER_WORDS, 40);
        end else if (pick == 4) begin
          mask[dsd_pkg::CHANNELS-1:0] =
            dsd_pkg::CHANNELS'(1) << $urandom_range(0, dsd_pkg::CHANNELS - 1);
          len = $urandom_range(dsd_pkg::HEADER_WORDS, 20);
        end
        send_event({len[dsd_pkg::POS_BITS-1:0], 2'($urandom_range(0, 3))}, mask);
      end
    end

    // largest possible event, left open at the end of the run
    calm <= 1'b1;
    send_word('1);
    for (int i = 1; i < TAIL_WORDS; i++) begin
      send_word((i == int'(dsd_pkg::MASK_WORD)) ? '1 : data_word());
    end
    in_valid <= 1'b0;

    // drain the outstanding samples
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d stream words in %0d events, %0d samples checked",
             words_sent, n_events, n_samples);
    $display("summary: receiver hold-off of %0d cycles %0s, %0d mismatches",
             HOLD_CYCLES, hold_done ? "applied" : "not reached", n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dsd_pkg.sv
hdl/dsd_div.sv
hdl/digitizer_event_sample_deframer.sv
tb/sv/dsd_sample_checker.sv
tb/sv/tb_digitizer_event_sample_deframer.sv
